// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl core (summed_area_table_core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/sat_pkg.sv -----
package sat_pkg;

  // payload widths
  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 64;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 11'd1024;

  // default size limits
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

endpackage

// ----- rtl/sat_channels.sv -----
// sample beats into the block
interface sat_in_if;
  import sat_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

// result beats out of the block
interface sat_out_if;
  import sat_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] prefix_sum;
  logic                    frame_last;

  modport source (output valid, output prefix_sum, output frame_last, input ready);
  modport sink   (input valid, input prefix_sum, input frame_last, output ready);
endinterface

// ----- rtl/sat_ram.sv -----
module sat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/summed_area_table_core.sv -----
// channel     | dir | payload                         | handshake
// ------------+-----+---------------------------------+------------
// sample_ch   | in  | sample_value (s32)              | valid/ready
// result_ch   | out | prefix_sum (s64), frame_last    | valid/ready
// cfg_*       | in  | cfg_index, cfg_data (11 bits)   | cfg_we only
//
// One sample per cycle sustained while result_ch is ready; a taken sample
// loads the add stage with the line-store read, then its sum is written back
// and loaded into the output register, from which result_ch takes it. The
// line-store read/write pair sets the rate; a back-to-back access to the same
// column is forwarded. Reset clears counters and running sum and sets both
// sizes to 1024; the line store is not cleared. A stalled result_ch holds
// the add stage, and sample_ch ready drops only while that stage cannot move.
`include "assert_macros.svh"

module summed_area_table_core #(
  parameter int MAX_COLUMNS = sat_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = sat_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sat_pkg::CFG_W-1:0]      cfg_data,
  sat_in_if.sink                         sample_ch,
  sat_out_if.source                      result_ch
);
  import sat_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CMP_W = ($clog2(MAX_COLUMNS + 1) > CFG_W) ?
                             $clog2(MAX_COLUMNS + 1) : CFG_W;
  localparam int ROW_CMP_W = ($clog2(MAX_ROWS + 1) > CFG_W) ?
                             $clog2(MAX_ROWS + 1) : CFG_W;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  // position and row state
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [SUM_W-1:0] row_sum;

  // add stage
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [SUM_W-1:0] s1_run;
  logic             s1_top;
  logic             s1_last;
  logic             fwd_valid;
  logic [SUM_W-1:0] fwd_data;

  // output register
  logic             out_valid;
  logic [SUM_W-1:0] out_sum;
  logic             out_last;

  logic                 accept;
  logic                 out_free;
  logic                 s1_adv;
  logic [COL_CMP_W-1:0] width_cfg;
  logic [COL_CMP_W-1:0] width_eff;
  logic [COL_CMP_W-1:0] width_m1;
  logic [COL_CMP_W-1:0] col_ext;
  logic [COL_CMP_W-1:0] col_cur;
  logic [ROW_CMP_W-1:0] height_cfg;
  logic [ROW_CMP_W-1:0] height_eff;
  logic [ROW_CMP_W-1:0] height_m1;
  logic [COL_W-1:0]     col_addr;
  logic                 row_end;
  logic                 frame_end;
  logic [SUM_W-1:0]     sample_ext;
  logic [SUM_W-1:0]     run_next;
  logic [SUM_W-1:0]     ram_rdata;
  logic [SUM_W-1:0]     above;
  logic [SUM_W-1:0]     s1_sum;

  // handshake
  assign out_free         = !out_valid || result_ch.ready;
  assign s1_adv           = s1_valid && out_free;
  assign sample_ch.ready  = !s1_valid || out_free;
  assign accept           = sample_ch.valid && sample_ch.ready;

  // effective sizes: zero reads as one, large values saturate
  always_comb begin
    width_cfg  = COL_CMP_W'(frame_width);
    height_cfg = ROW_CMP_W'(frame_height);
    if (frame_width == '0) begin
      width_eff = COL_CMP_W'(1);
    end else if (width_cfg > COL_CMP_W'(MAX_COLUMNS)) begin
      width_eff = COL_CMP_W'(MAX_COLUMNS);
    end else begin
      width_eff = width_cfg;
    end
    if (frame_height == '0) begin
      height_eff = ROW_CMP_W'(1);
    end else if (height_cfg > ROW_CMP_W'(MAX_ROWS)) begin
      height_eff = ROW_CMP_W'(MAX_ROWS);
    end else begin
      height_eff = height_cfg;
    end
    width_m1  = width_eff - COL_CMP_W'(1);
    height_m1 = height_eff - ROW_CMP_W'(1);
  end

  // current column, clamped to the last one when the width shrank
  assign col_ext   = COL_CMP_W'(col_pos);
  assign row_end   = col_ext >= width_m1;
  assign col_cur   = row_end ? width_m1 : col_ext;
  assign col_addr  = col_cur[COL_W-1:0];
  assign frame_end = row_end && (ROW_CMP_W'(row_pos) >= height_m1);

  // running row sum
  assign sample_ext = {{(SUM_W - SAMPLE_W){sample_ch.sample_value[SAMPLE_W-1]}},
                       sample_ch.sample_value};
  assign run_next   = row_sum + sample_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_SIZE_RESET;
      frame_height <= FRAME_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // counters and running sum advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      row_sum <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos <= '0;
        row_sum <= '0;
        row_pos <= frame_end ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_addr + COL_W'(1);
        row_sum <= run_next;
      end
    end
  end

  // line store of the previous row's sums
  sat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_sum),
    .re    (accept),
    .raddr (col_addr),
    .rdata (ram_rdata)
  );

  // add stage: running sum plus the entry above
  assign above  = fwd_valid ? fwd_data : ram_rdata;
  assign s1_sum = s1_run + (s1_top ? '0 : above);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (accept) begin
      s1_valid  <= 1'b1;
      fwd_valid <= s1_adv && (s1_col == col_addr);
    end else if (s1_adv) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_addr;
      s1_run   <= run_next;
      s1_top   <= (row_pos == '0);
      s1_last  <= frame_end;
      fwd_data <= s1_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum  <= s1_sum;
      out_last <= s1_last;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.prefix_sum = out_sum;
  assign result_ch.frame_last = out_last;

  // checks
  `ASSERT_IMPLIES(a_fwd_needs_stage, clk, rst, fwd_valid, s1_valid)
  `ASSERT_IMPLIES(a_col_in_range, clk, rst, 1'b1, COL_CMP_W'(col_pos) < width_eff ||
                  COL_CMP_W'(col_pos) < COL_CMP_W'(MAX_COLUMNS))
  `ASSERT_NEXT(a_frame_wrap, clk, rst, accept && frame_end, col_pos == '0 && row_pos == '0)
  `ASSERT_NEXT(a_row_wrap, clk, rst, accept && row_end, row_sum == '0 && col_pos == '0)
  `ASSERT_NEXT(a_stage_loaded, clk, rst, accept, s1_valid)

endmodule

// ----- tb/tb_summed_area_table_core.sv -----
`timescale 1ns / 1ps

module tb_summed_area_table_core;
  import sat_pkg::*;

  localparam int MAX_COLS    = DEF_MAX_COLUMNS;
  localparam int MAX_LINES   = DEF_MAX_ROWS;
  localparam int SAMPLE_GOAL = 1650;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } sat_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sat_in_if  in_ch ();
  sat_out_if out_ch ();

  summed_area_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (in_ch),
    .result_ch (out_ch)
  );

  // samples waiting for the driver, sums waiting for the monitor
  logic signed [SAMPLE_W-1:0] sample_q[$];
  sat_result_t                pending_sums[$];

  // integral image state mirrored in the testbench
  logic [SUM_W-1:0] line_sums [MAX_COLS];
  logic [SUM_W-1:0] run_sum = '0;
  int               col_pos = 0;
  int               row_pos = 0;
  int               cols_written = 0;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // run bookkeeping
  int err_count = 0;
  int samples_sent = 0;
  int samples_issued = 0;
  int sums_seen = 0;
  int frames_closed = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit idle_on = 1'b1;

  function automatic int eff_size(input logic [CFG_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // one prefix sum per sample: running row sum plus the entry above
  function automatic void integrate_sample(input logic signed [SAMPLE_W-1:0] s);
    int               w;
    int               h;
    int               col;
    bit               row_end;
    bit               frame_end;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] total;
    sat_result_t      r;
    w = eff_size(width_reg, MAX_COLS);
    h = eff_size(height_reg, MAX_LINES);
    col = (col_pos >= w) ? w - 1 : col_pos;
    row_end = (col + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    run_sum = run_sum + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
    above = (row_pos == 0) ? '0 : line_sums[col];
    total = run_sum + above;
    line_sums[col] = total;
    if (col + 1 > cols_written) cols_written = col + 1;
    if (row_end) begin
      run_sum = '0;
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col + 1;
    end
    r.sum = total;
    r.last = frame_end;
    pending_sums.push_back(r);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 70) return 32'sh7FFF_FFFF;
    if (r < 80) return 32'sh8000_0000;
    return $urandom_range(0, 20) - 10;
  endfunction

  // small sizes most of the time, extremes and saturating values sometimes
  function automatic logic [CFG_W-1:0] pick_size(input bit is_width);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return is_width ? CFG_W'($urandom_range(1, 12)) : CFG_W'($urandom_range(1, 6));
    if (r < 80) return CFG_W'($urandom_range(13, 40));
    if (r < 85) return '0;
    if (r < 90) return FRAME_SIZE_RESET;
    if (r < 94) return '1;
    return CFG_W'($urandom_range(1025, 2046));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    reg_writes++;
  endtask

  // block drained: nothing queued, nothing on the wire, no sum outstanding
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_ch.valid || samples_issued != sums_seen ||
           pending_sums.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_samples(input int n);
    repeat (n) sample_q.push_back(pick_sample());
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid        <= 1'b0;
      in_ch.sample_value <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        integrate_sample(in_ch.sample_value);
        samples_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_ch.valid        <= 1'b1;
          in_ch.sample_value <= sample_q.pop_front();
          samples_issued++;
          send_gap = idle_on ? pick_gap() : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    sat_result_t exp_r;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sums_seen++;
        if (pending_sums.size() == 0) begin
          $display("%0t unexpected beat: prefix_sum %0d frame_last %0b",
                   $time, out_ch.prefix_sum, out_ch.frame_last);
          err_count++;
        end else begin
          exp_r = pending_sums.pop_front();
          if (out_ch.prefix_sum !== exp_r.sum) begin
            $display("%0t prefix_sum mismatch: expected %0d actual %0d",
                     $time, exp_r.sum, out_ch.prefix_sum);
            err_count++;
          end
          if (out_ch.frame_last !== exp_r.last) begin
            $display("%0t frame_last mismatch: expected %0b actual %0b",
                     $time, exp_r.last, out_ch.frame_last);
            err_count++;
          end
          if (exp_r.last) frames_closed++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < 20) recv_stall = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t watchdog expired with %0d sums outstanding", $time, pending_sums.size());
      $display("[summed_area_table_core] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int               change;
    int               n;
    int               w;
    int               h;
    int               rows_left;
    int               cc;
    int               left;
    logic [CFG_W-1:0] new_w;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    width_reg          = FRAME_SIZE_RESET;
    height_reg         = FRAME_SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset sizes, field extremes on the first row
    sample_q.push_back(32'sh7FFF_FFFF);
    sample_q.push_back(32'sh8000_0000);
    sample_q.push_back(32'sh0000_0000);
    sample_q.push_back(-32'sd1);
    sample_q.push_back(32'sd1);
    sample_q.push_back(32'sh7FFF_FFFF);
    wait_idle();

    // width shrunk below the column counter: row ends on the next beat
    write_reg(REG_FRAME_WIDTH, 11'd3);
    push_samples(4);
    wait_idle();

    // height shrunk below the row counter: this row closes the frame
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    push_samples(3);
    wait_idle();

    // zero sizes act as one: every beat closes a frame
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    sample_q.push_back(32'sh7FFF_FFFF);
    sample_q.push_back(32'sh7FFF_FFFF);
    sample_q.push_back(32'sh8000_0000);
    wait_idle();

    // oversized values saturate to the limits
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, '1);
    push_samples(3);
    wait_idle();

    // single column, full height
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, FRAME_SIZE_RESET);
    push_samples(2);

    // random phases
    while (samples_sent + sample_q.size() < SAMPLE_GOAL) begin
      change = $urandom_range(0, 3);
      if (change != 0 || $urandom_range(0, 1) == 1) wait_idle();
      if (change[0]) begin
        new_w = pick_size(1'b1);
        // below the first row, only columns already in the line store may be read
        if (row_pos != 0 && eff_size(new_w, MAX_COLS) > cols_written)
          new_w = CFG_W'($urandom_range(1, cols_written));
        write_reg(REG_FRAME_WIDTH, new_w);
      end
      if (change[1]) write_reg(REG_FRAME_HEIGHT, pick_size(1'b0));
      idle_on = ($urandom_range(0, 3) != 0);
      w = eff_size(width_reg, MAX_COLS);
      h = eff_size(height_reg, MAX_LINES);
      rows_left = (h > row_pos) ? h - row_pos : 1;
      cc = (col_pos >= w) ? w - 1 : col_pos;
      left = rows_left * w - cc;
      // often run up to a frame end, sometimes into the next frames
      if (left <= 150 && $urandom_range(0, 1) == 1)
        n = left + ((w * h <= 60) ? $urandom_range(0, 2 * w * h) : 0);
      else
        n = $urandom_range(5, 60);
      push_samples(n);
    end

    wait_idle();
    $display("covered %0d samples and %0d checked sums over %0d closed frames",
             samples_sent, sums_seen, frames_closed);
    $display("with %0d size register writes, zero, saturating and mid-frame sizes included",
             reg_writes);
    if (err_count == 0) begin
      $display("[summed_area_table_core] OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[summed_area_table_core] ERROR");
    end
    $finish;
  end

endmodule
